@@ hw/rtl/cfcr_pkg.sv @@
`default_nettype none
package cfcr_pkg;

   localparam int MAX_FRAME_BYTES_DEFAULT = 256;

   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 9;
   localparam int CRC_W   = 16;
   localparam int PAYLOAD_BYTES = 5;

   localparam int CSR_INDEX_W = 2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_VALUE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGHEST_COMMAND = 2'd1;

   localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] HIGHEST_RESET = 8'd12;

   localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   localparam logic [COUNT_W-1:0] COUNT_TOP     = 9'd511;
   localparam logic [COUNT_W-1:0] BYTES_OUT_TOP = 9'd256;
   localparam logic [COUNT_W:0]   LEN_OVERHEAD  = 10'd5;

   // frame status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD     = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [BYTE_W-1:0] payload_type [PAYLOAD_BYTES];

   // everything the back end needs to judge and decode one finished frame
   typedef struct packed {
      logic [CRC_W-1:0]   crc;
      logic [CRC_W-1:0]   tail;
      logic [COUNT_W-1:0] frame_bytes;
      logic [BYTE_W-1:0]  first_byte;
      logic [BYTE_W-1:0]  command;
      logic [BYTE_W-1:0]  length;
      logic [PAYLOAD_BYTES*BYTE_W-1:0] payload;
   } frame_rec_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_value;
      logic [BYTE_W-1:0] highest_command;
   } csr_type;

   function automatic logic [CRC_W-1:0] crc16_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cfcr_front.sv @@
`default_nettype none
module cfcr_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            rx_byte,
   input  wire logic                  end_of_frame,
   output logic                       push,
   output cfcr_pkg::frame_rec_type    push_rec
);
   import cfcr_pkg::*;

   logic [CRC_W-1:0]   crc_ff, crc_in, crc_upd;
   logic [COUNT_W-1:0] count_ff, count_in, count_upd;
   logic [BYTE_W-1:0]  dly0_ff, dly0_in, dly1_ff, dly1_in;
   logic [BYTE_W-1:0]  first_ff, first_in, first_upd;
   logic [BYTE_W-1:0]  cmd_ff, cmd_in, cmd_upd;
   logic [BYTE_W-1:0]  len_ff, len_in, len_upd;
   payload_type        pay_ff, pay_in, pay_upd;
   logic               finish;

   always_comb begin
      // CRC trails the input by two bytes
      crc_upd   = (count_ff >= 9'd2) ? crc16_feed(crc_ff, dly1_ff) : crc_ff;
      count_upd = (count_ff < COUNT_TOP) ? count_ff + 9'd1 : COUNT_TOP;
      first_upd = (count_ff == 9'd0) ? rx_byte : first_ff;
      cmd_upd   = (count_ff == 9'd1) ? rx_byte : cmd_ff;
      len_upd   = (count_ff == 9'd2) ? rx_byte : len_ff;
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         pay_upd[k] = (count_ff == COUNT_W'(k + 3)) ? rx_byte : pay_ff[k];
      end

      finish = accept && end_of_frame;

      push_rec.crc         = crc_upd;
      push_rec.tail        = {dly0_ff, rx_byte};
      push_rec.frame_bytes = count_upd;
      push_rec.first_byte  = first_upd;
      push_rec.command     = cmd_upd;
      push_rec.length      = len_upd;
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         push_rec.payload[k*BYTE_W +: BYTE_W] = pay_upd[k];
      end

      crc_in   = crc_ff;
      count_in = count_ff;
      dly0_in  = dly0_ff;
      dly1_in  = dly1_ff;
      first_in = first_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      pay_in   = pay_ff;
      if (finish) begin
         // drop all frame state once the record is handed off
         crc_in   = CRC_INIT;
         count_in = '0;
         dly0_in  = '0;
         dly1_in  = '0;
         first_in = '0;
         cmd_in   = '0;
         len_in   = '0;
         for (int k = 0; k < PAYLOAD_BYTES; k++) pay_in[k] = '0;
      end else if (accept) begin
         crc_in   = crc_upd;
         count_in = count_upd;
         dly0_in  = rx_byte;
         dly1_in  = dly0_ff;
         first_in = first_upd;
         cmd_in   = cmd_upd;
         len_in   = len_upd;
         pay_in   = pay_upd;
      end
   end

   assign push = finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         count_ff <= '0;
         dly0_ff  <= '0;
         dly1_ff  <= '0;
         first_ff <= '0;
         cmd_ff   <= '0;
         len_ff   <= '0;
         for (int k = 0; k < PAYLOAD_BYTES; k++) pay_ff[k] <= '0;
      end else begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         dly0_ff  <= dly0_in;
         dly1_ff  <= dly1_in;
         first_ff <= first_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         pay_ff   <= pay_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/cfcr_queue.sv @@
`default_nettype none
module cfcr_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire cfcr_pkg::frame_rec_type push_rec,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       head_valid,
   output cfcr_pkg::frame_rec_type    head_rec
);
   import cfcr_pkg::*;

   frame_rec_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_rec   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_rec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/cfcr_back.sv @@
`default_nettype none
module cfcr_back #(
   parameter int MAX_FRAME_BYTES = cfcr_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfcr_pkg::csr_type     csr,
   input  wire logic                  head_valid,
   input  wire cfcr_pkg::frame_rec_type head_rec,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_frame_status,
   output logic [7:0]                 rsp_command_code,
   output logic [8:0]                 rsp_frame_bytes,
   output logic [7:0]                 rsp_axis_select,
   output logic [7:0]                 rsp_direction_byte,
   output logic [15:0]                rsp_step_count,
   output logic [15:0]                rsp_speed_word,
   output logic [31:0]                rsp_angle_bits
);
   import cfcr_pkg::*;

   localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(MAX_FRAME_BYTES);

   logic        valid_ff, valid_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  cmd_ff;
   logic [8:0]  bytes_ff, bytes_in;
   logic [39:0] pay_ff;
   logic        bad;

   assign pop = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      bad = (head_rec.frame_bytes < 9'd2) || (head_rec.frame_bytes > FRAME_LIMIT)
         || (head_rec.crc != head_rec.tail)
         || (head_rec.first_byte != csr.header_value)
         || ({1'b0, head_rec.frame_bytes} != ({2'b00, head_rec.length} + LEN_OVERHEAD));
      if (bad) status_in = STATUS_BAD;
      else if (head_rec.command > csr.highest_command) status_in = STATUS_UNKNOWN;
      else status_in = STATUS_OK;
      bytes_in = (head_rec.frame_bytes > BYTES_OUT_TOP) ? BYTES_OUT_TOP
                                                        : head_rec.frame_bytes;
      if (pop) valid_in = 1'b1;
      else if (!rsp_stall) valid_in = 1'b0;
      else valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= status_in;
         cmd_ff    <= head_rec.command;
         bytes_ff  <= bytes_in;
         pay_ff    <= head_rec.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_frame_status   = status_ff;
   assign rsp_command_code   = cmd_ff;
   assign rsp_frame_bytes    = bytes_ff;
   assign rsp_axis_select    = pay_ff[7:0];
   assign rsp_direction_byte = pay_ff[15:8];
   assign rsp_step_count     = {pay_ff[23:16], pay_ff[31:24]};
   assign rsp_speed_word     = {pay_ff[7:0], pay_ff[15:8]};
   assign rsp_angle_bits     = pay_ff[39:8];

endmodule
`default_nettype wire

@@ hw/rtl/crc16_framed_command_receiver_top.sv @@
// Framed command receiver with a CRC-16/MODBUS check.
//
// req_*: one received byte per item, req_end_of_frame on the last byte of a
//   frame. A byte is taken at each edge with req_valid high and req_stall low.
// rsp_*: one item per frame: status (accepted, bad, unknown command), the
//   command code, the saturated byte count and the decoded argument fields.
// csr_*: register writes (index 0 header value, index 1 highest command);
//   always ready, write only while no frame is in flight.
// Throughput: one byte per cycle while req_stall is low. The front end updates
//   the CRC over one byte per cycle; a finished frame record enters a two-entry
//   queue and the back end judges it into the output register.
// Path: a frame record passes the queue, then the output register sets rsp_valid.
// Stall: a stalled result holds in the output register; the queue keeps
//   absorbing frames and req_stall rises only when it holds two waiting frames.
// Reset: clears the frame state, the queue and the output valid, and sets the
//   registers to header 0xAA and highest command 12.
`default_nettype none
module crc16_framed_command_receiver_top #(
   parameter int MAX_FRAME_BYTES = cfcr_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [7:0]                      req_rx_byte,
   input  wire logic                            req_end_of_frame,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [1:0]                           rsp_frame_status,
   output logic [7:0]                           rsp_command_code,
   output logic [8:0]                           rsp_frame_bytes,
   output logic [7:0]                           rsp_axis_select,
   output logic [7:0]                           rsp_direction_byte,
   output logic [15:0]                          rsp_step_count,
   output logic [15:0]                          rsp_speed_word,
   output logic [31:0]                          rsp_angle_bits,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [cfcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                      csr_data
);
   import cfcr_pkg::*;

   csr_type       csr_ff, csr_in;
   logic          accept;
   logic          push, full, pop, head_valid;
   frame_rec_type push_rec, head_rec;

   // take a byte whenever the queue has room for a finished frame
   assign req_stall = full;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // register writes; unknown indexes are dropped
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEADER_VALUE:    csr_in.header_value    = csr_data;
            CSR_HIGHEST_COMMAND: csr_in.highest_command = csr_data;
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.header_value    <= HEADER_RESET;
         csr_ff.highest_command <= HIGHEST_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   cfcr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .end_of_frame (req_end_of_frame),
      .push         (push),
      .push_rec     (push_rec)
   );

   cfcr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   cfcr_back #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .csr                (csr_ff),
      .head_valid         (head_valid),
      .head_rec           (head_rec),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_command_code   (rsp_command_code),
      .rsp_frame_bytes    (rsp_frame_bytes),
      .rsp_axis_select    (rsp_axis_select),
      .rsp_direction_byte (rsp_direction_byte),
      .rsp_step_count     (rsp_step_count),
      .rsp_speed_word     (rsp_speed_word),
      .rsp_angle_bits     (rsp_angle_bits)
   );

endmodule
`default_nettype wire

@@ verif/crc16_framed_command_receiver_top_test.sv @@
`default_nettype none
module crc16_framed_command_receiver_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cfcr_pkg::*;

   localparam int CLOCK_HALF_NS = 6;
   localparam int RESET_CYCLES  = 4;
   localparam int FRAME_LIMIT   = MAX_FRAME_BYTES_DEFAULT;
   // extra idle margin after every expected result is back
   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_LIMIT_NS  = 5_000_000;
   localparam int REPORT_LIMIT  = 10;
   localparam int RANDOM_FILL   = -1;

   // register indexes that decode to nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  command;
      logic [8:0]  nbytes;
      logic [7:0]  axis;
      logic [7:0]  direction;
      logic [15:0] steps;
      logic [15:0] speed;
      logic [31:0] angle;
   } frame_result_type;

   // ---------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_rx_byte      = 8'h00;
   logic                   req_end_of_frame = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [1:0]             rsp_frame_status;
   logic [7:0]             rsp_command_code;
   logic [8:0]             rsp_frame_bytes;
   logic [7:0]             rsp_axis_select;
   logic [7:0]             rsp_direction_byte;
   logic [15:0]            rsp_step_count;
   logic [15:0]            rsp_speed_word;
   logic [31:0]            rsp_angle_bits;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [7:0]             csr_data         = 8'h00;

   crc16_framed_command_receiver_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .req_end_of_frame   (req_end_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_command_code   (rsp_command_code),
      .rsp_frame_bytes    (rsp_frame_bytes),
      .rsp_axis_select    (rsp_axis_select),
      .rsp_direction_byte (rsp_direction_byte),
      .rsp_step_count     (rsp_step_count),
      .rsp_speed_word     (rsp_speed_word),
      .rsp_angle_bits     (rsp_angle_bits),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #CLOCK_HALF_NS clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #RUN_LIMIT_NS;
      $display("crc16_framed_command_receiver_top_test NOT OK");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Frame predictor: own copy of the receiver state and registers
   // ---------------------------------------------------------------------
   logic [7:0]       cfg_header;
   logic [7:0]       cfg_highest;
   logic [15:0]      crc_acc;
   logic [8:0]       rx_count;
   logic [7:0]       tail_pipe [2];
   logic [7:0]       hdr_seen;
   logic [7:0]       cmd_seen;
   logic [7:0]       len_seen;
   logic [7:0]       arg_seen [5];
   frame_result_type pending_results [$];

   int fault_count;
   int bytes_sent;
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_remaining;

   // CRC-16/MODBUS over one byte, LSB first
   function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc,
                                                   input logic [7:0] octet);
      logic [15:0] r;
      r = acc ^ {8'h00, octet};
      for (int bit_n = 0; bit_n < 8; bit_n++) begin
         if (r[0]) r = (r >> 1) ^ CRC_POLY;
         else r = r >> 1;
      end
      return r;
   endfunction

   function automatic void clear_frame_state();
      crc_acc  = CRC_INIT;
      rx_count = '0;
      hdr_seen = '0;
      cmd_seen = '0;
      len_seen = '0;
      foreach (tail_pipe[i]) tail_pipe[i] = '0;
      foreach (arg_seen[i]) arg_seen[i] = '0;
   endfunction

   // Advance the predictor by one accepted byte; queue a result on frame end.
   function automatic void predict_frame_byte(input logic [7:0] octet, input logic last);
      logic [8:0]       idx;
      logic [8:0]       cnt;
      logic [7:0]       prev;
      logic             bad;
      frame_result_type r;
      idx  = rx_count;
      cnt  = (idx < COUNT_TOP) ? idx + 9'd1 : COUNT_TOP;
      prev = tail_pipe[0];
      // the CRC trails the stream by two bytes
      if (idx >= 9'd2) crc_acc = modbus_crc_byte(crc_acc, tail_pipe[1]);
      tail_pipe[1] = tail_pipe[0];
      tail_pipe[0] = octet;
      if (idx == 9'd0) hdr_seen = octet;
      else if (idx == 9'd1) cmd_seen = octet;
      else if (idx == 9'd2) len_seen = octet;
      else if (idx <= 9'd7) arg_seen[idx - 9'd3] = octet;
      rx_count = cnt;
      if (!last) return;

      bad = (cnt < 9'd2) || (int'(cnt) > FRAME_LIMIT) || (crc_acc != {prev, octet})
         || (hdr_seen != cfg_header)
         || (int'(cnt) != int'(len_seen) + int'(LEN_OVERHEAD));
      if (bad) r.status = STATUS_BAD;
      else if (cmd_seen > cfg_highest) r.status = STATUS_UNKNOWN;
      else r.status = STATUS_OK;
      r.command   = cmd_seen;
      r.nbytes    = (cnt > BYTES_OUT_TOP) ? BYTES_OUT_TOP : cnt;
      r.axis      = arg_seen[0];
      r.direction = arg_seen[1];
      r.steps     = {arg_seen[2], arg_seen[3]};
      r.speed     = {arg_seen[0], arg_seen[1]};
      r.angle     = {arg_seen[4], arg_seen[3], arg_seen[2], arg_seen[1]};
      pending_results.push_back(r);
      clear_frame_state();
   endfunction

   function automatic string describe(input frame_result_type r);
      return $sformatf("status=%0d cmd=%02h bytes=%0d axis=%02h dir=%02h steps=%04h %s",
                       r.status, r.command, r.nbytes, r.axis, r.direction, r.steps,
                       $sformatf("speed=%04h angle=%08h", r.speed, r.angle));
   endfunction

   // ---------------------------------------------------------------------
   // Monitors: sample at the edge, before any driver update lands
   // ---------------------------------------------------------------------

   // Feed every accepted byte and every register write to the predictor.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predict_frame_byte(req_rx_byte, req_end_of_frame);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEADER_VALUE:    cfg_header = csr_data;
               CSR_HIGHEST_COMMAND: cfg_highest = csr_data;
               default: ;
            endcase
         end
      end
   end

   // Compare each accepted result against the oldest expectation.
   always @(posedge clock) begin : check_results
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status    = rsp_frame_status;
         got.command   = rsp_command_code;
         got.nbytes    = rsp_frame_bytes;
         got.axis      = rsp_axis_select;
         got.direction = rsp_direction_byte;
         got.steps     = rsp_step_count;
         got.speed     = rsp_speed_word;
         got.angle     = rsp_angle_bits;
         if (pending_results.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected frame result: %s", describe(got));
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("frame result mismatch at %0t", $realtime);
                  $display("   expected %s", describe(want));
                  $display("   actual   %s", describe(got));
               end
            end
         end
      end
   end

   // Receiver: hold off for a counted stretch on request, else stall at random.
   always @(posedge clock) begin
      if (hold_remaining > 0) begin
         rsp_stall      <= 1'b1;
         hold_remaining <= hold_remaining - 1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   logic [7:0] frame_buf [$];

   // Offer one byte, idling first at the current rate; return once it is taken.
   task automatic send_byte(input logic [7:0] octet, input logic last);
      while (sender_idle_pct != 0 && $urandom_range(99, 0) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_rx_byte      <= octet;
      req_end_of_frame <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   // Build header, command, length, body and a correct trailing CRC (high byte first).
   function automatic void build_frame(input logic [7:0] hdr, input logic [7:0] cmd,
                                       input logic [7:0] len, input int body_len,
                                       input int fill);
      logic [15:0] c;
      frame_buf.delete();
      frame_buf.push_back(hdr);
      frame_buf.push_back(cmd);
      frame_buf.push_back(len);
      repeat (body_len) frame_buf.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      c = CRC_INIT;
      foreach (frame_buf[i]) c = modbus_crc_byte(c, frame_buf[i]);
      frame_buf.push_back(c[15:8]);
      frame_buf.push_back(c[7:0]);
   endfunction

   function automatic void build_noise(input int n);
      frame_buf.delete();
      repeat (n) frame_buf.push_back(8'($urandom));
   endfunction

   // Drop valid, wait out every expected result, then let the pipeline empty.
   task automatic settle();
      req_valid <= 1'b0;
      // let the predictor take the byte accepted at this edge first
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only call with the block idle (after settle).
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, each verdict, short frames and bytes never received.
   task automatic test_directed_frames();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // smallest good frame: CRC bytes land in the argument fields
      build_frame(HEADER_RESET, 8'd0, 8'd0, 0, RANDOM_FILL);
      send_frame();
      // command at the limit, just above it, and at the top
      build_frame(HEADER_RESET, HIGHEST_RESET, 8'd5, 5, RANDOM_FILL);
      send_frame();
      build_frame(HEADER_RESET, HIGHEST_RESET + 8'd1, 8'd2, 2, RANDOM_FILL);
      send_frame();
      build_frame(HEADER_RESET, 8'hFF, 8'd3, 3, RANDOM_FILL);
      send_frame();
      // argument bytes all ones, then all zeros
      build_frame(HEADER_RESET, 8'd7, 8'd8, 8, 8'hFF);
      send_frame();
      build_frame(HEADER_RESET, 8'd7, 8'd8, 8, 8'h00);
      send_frame();
      // wrong header
      build_frame(8'h55, 8'd1, 8'd4, 4, RANDOM_FILL);
      send_frame();
      // corrupt CRC low byte, then high byte
      build_frame(HEADER_RESET, 8'd2, 8'd4, 4, RANDOM_FILL);
      frame_buf[frame_buf.size() - 1] ^= 8'h01;
      send_frame();
      build_frame(HEADER_RESET, 8'd2, 8'd4, 4, RANDOM_FILL);
      frame_buf[frame_buf.size() - 2] ^= 8'h80;
      send_frame();
      // length byte one too high, and one too low
      build_frame(HEADER_RESET, 8'd1, 8'd4, 3, RANDOM_FILL);
      send_frame();
      build_frame(HEADER_RESET, 8'd1, 8'd2, 3, RANDOM_FILL);
      send_frame();
      // one-byte frame, two-byte frame, then three and four bytes
      frame_buf = '{HEADER_RESET};
      send_frame();
      frame_buf = '{HEADER_RESET, 8'h01};
      send_frame();
      build_noise(3);
      send_frame();
      build_noise(4);
      send_frame();
      // only part of the argument bytes present
      build_frame(HEADER_RESET, 8'd9, 8'd1, 1, RANDOM_FILL);
      send_frame();
      // good frame after all the bad ones: state must be clean
      build_frame(HEADER_RESET, 8'd4, 8'd6, 6, RANDOM_FILL);
      send_frame();
      settle();
   endtask

   // Size limit, frame_bytes and counter saturation.
   task automatic test_long_frames();
      build_frame(HEADER_RESET, 8'd3, 8'd251, 251, RANDOM_FILL);   // exactly the limit
      send_frame();
      build_frame(HEADER_RESET, 8'd3, 8'd252, 252, RANDOM_FILL);   // one byte over
      send_frame();
      build_frame(HEADER_RESET, 8'd3, 8'd255, 2, RANDOM_FILL);     // length byte at top
      send_frame();
      build_noise(520);                                            // past counter top
      send_frame();
      build_frame(HEADER_RESET, 8'd5, 8'd2, 2, RANDOM_FILL);
      send_frame();
      settle();
   endtask

   // Spare indexes are ignored; then both registers at their extremes.
   task automatic test_register_writes();
      write_csr(CSR_SPARE_2, 8'h00);
      write_csr(CSR_SPARE_3, 8'hFF);
      build_frame(HEADER_RESET, HIGHEST_RESET, 8'd1, 1, RANDOM_FILL);
      send_frame();
      build_frame(HEADER_RESET, HIGHEST_RESET + 8'd1, 8'd1, 1, RANDOM_FILL);
      send_frame();
      settle();

      write_csr(CSR_HEADER_VALUE, 8'h00);
      write_csr(CSR_HIGHEST_COMMAND, 8'h00);
      build_frame(8'h00, 8'h00, 8'd3, 3, RANDOM_FILL);
      send_frame();
      build_frame(8'h00, 8'h01, 8'd3, 3, RANDOM_FILL);
      send_frame();
      build_frame(HEADER_RESET, 8'h00, 8'd3, 3, RANDOM_FILL);
      send_frame();
      settle();

      write_csr(CSR_HEADER_VALUE, 8'hFF);
      write_csr(CSR_HIGHEST_COMMAND, 8'hFF);
      build_frame(8'hFF, 8'hFF, 8'd5, 5, RANDOM_FILL);
      send_frame();
      build_frame(8'hFE, 8'hFF, 8'd5, 5, RANDOM_FILL);
      send_frame();
      settle();
   endtask

   // Hold the receiver off while the sender keeps going, so the block fills.
   task automatic test_backpressure();
      write_csr(CSR_HEADER_VALUE, HEADER_RESET);
      write_csr(CSR_HIGHEST_COMMAND, HIGHEST_RESET);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_remaining     = 300;
      repeat (16) begin
         build_frame(cfg_header, 8'($urandom_range(cfg_highest, 0)), 8'd0, 0, RANDOM_FILL);
         send_frame();
      end
      // pause the sender until every result is back
      settle();
      receiver_stall_pct = 59;
      hold_remaining     = 150;
      repeat (12) begin
         build_frame(cfg_header, 8'($urandom), 8'd1, 1, RANDOM_FILL);
         send_frame();
      end
      settle();
   endtask

   // Mostly well-formed frames with random content, the rest broken or noise.
   task automatic run_random(input int target, input int idle_pct, input int stall_pct);
      int         kind;
      int         body;
      logic [7:0] cmd;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      bytes_sent         = 0;
      while (bytes_sent < target) begin
         kind = $urandom_range(99, 0);
         body = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 0) : $urandom_range(8, 0);
         cmd  = $urandom_range(1, 0) ? 8'($urandom_range(cfg_highest, 0)) : 8'($urandom);
         if (kind < 70) begin
            build_frame(cfg_header, cmd, 8'(body), body, RANDOM_FILL);
         end else if (kind < 78) begin
            // flip one bit anywhere
            build_frame(cfg_header, cmd, 8'(body), body, RANDOM_FILL);
            frame_buf[$urandom_range(frame_buf.size() - 1, 0)] ^= 8'(1 << $urandom_range(7, 0));
         end else if (kind < 83) begin
            build_frame(cfg_header ^ 8'($urandom_range(255, 1)), cmd, 8'(body), body,
                        RANDOM_FILL);
         end else if (kind < 88) begin
            build_frame(cfg_header, cmd, 8'(body + $urandom_range(3, 1)), body, RANDOM_FILL);
         end else if (kind < 95) begin
            build_noise($urandom_range(12, 1));
         end else if (kind < 99) begin
            build_noise($urandom_range(2, 1));
         end else begin
            body = $urandom_range(300, 240);
            build_frame(cfg_header, cmd, 8'(body), body, RANDOM_FILL);
         end
         send_frame();
      end
      settle();
   endtask

   task automatic test_random_traffic();
      write_csr(CSR_HEADER_VALUE, HEADER_RESET);
      write_csr(CSR_HIGHEST_COMMAND, HIGHEST_RESET);
      run_random(40, 0, 0);
      write_csr(CSR_HEADER_VALUE, 8'h00);
      write_csr(CSR_HIGHEST_COMMAND, 8'h00);
      run_random(40, 59, 0);
      write_csr(CSR_HEADER_VALUE, 8'hFF);
      write_csr(CSR_HIGHEST_COMMAND, 8'hFF);
      run_random(40, 0, 59);
      write_csr(CSR_HEADER_VALUE, 8'($urandom));
      write_csr(CSR_HIGHEST_COMMAND, 8'($urandom));
      run_random(40, 15, 15);
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      fault_count        = 0;
      bytes_sent         = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_remaining     = 0;
      cfg_header         = HEADER_RESET;
      cfg_highest        = HIGHEST_RESET;
      clear_frame_state();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_long_frames();
      test_register_writes();
      test_backpressure();
      test_random_traffic();

      settle();
      if (fault_count == 0 && pending_results.size() == 0) begin
         $display("crc16_framed_command_receiver_top_test OK");
      end else begin
         $display("crc16_framed_command_receiver_top_test NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ crc16_framed_command_receiver_top.f @@
hw/rtl/cfcr_pkg.sv
hw/rtl/cfcr_front.sv
hw/rtl/cfcr_queue.sv
hw/rtl/cfcr_back.sv
hw/rtl/crc16_framed_command_receiver_top.sv
verif/crc16_framed_command_receiver_top_test.sv
